/* rtl/core/assert_macros.svh */
// Assertion macros used by the port-level checker of this block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is high
`define MTSS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Concurrent assertion that also holds during reset
`define MTSS_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

/* rtl/core/mtss_pkg.sv */
// Package for the motion to scroll scaler: widths, register indexes,
// sequencer states and the control struct of the shared arithmetic unit.
package mtss_pkg;

   localparam int ACC_W      = 58;   // holds |delta * m * speed| plus carry
   localparam int CNT_W      = 6;
   localparam int DIV_STEPS  = 58;
   localparam int MUL1_STEPS = 19;   // unit_num * 8
   localparam int MUL2_STEPS = 21;   // speed_q16
   localparam int SQ_STEPS   = 16;
   localparam int GAIN_STEPS = 16;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;
   localparam int REG_IDX_W  = 3;
   localparam int REG_W      = 16;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_AXIS_INV  = 3'd0,
      REG_MIN_STEP  = 3'd1,
      REG_MAX_DELTA = 3'd2,
      REG_DEADZONE  = 3'd3,
      REG_GAIN_NUM  = 3'd4,
      REG_GAIN_DEN  = 3'd5,
      REG_UNIT_NUM  = 3'd6,
      REG_UNIT_DEN  = 3'd7
   } reg_idx_type;

   typedef enum logic [1:0] {
      MODE_VERT  = 2'd0,
      MODE_HORIZ = 2'd1,
      MODE_DRAG  = 2'd2,
      MODE_ALT   = 2'd3
   } wheel_mode_type;

   typedef enum logic [2:0] {
      AXIS_X      = 3'd0,
      AXIS_Y      = 3'd1,
      AXIS_VWHEEL = 3'd2,
      AXIS_HWHEEL = 3'd3
   } axis_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_ADDREM,
      ST_DIV,
      ST_CHK,
      ST_SQ,
      ST_GAIN,
      ST_CDIV,
      ST_FIN,
      ST_OUT
   } state_type;

   typedef enum logic {
      OP_MUL = 1'b0,
      OP_DIV = 1'b1
   } op_type;

   typedef struct packed {
      logic             start;
      op_type           op;
      logic [CNT_W-1:0] nbits;
   } unit_ctrl_type;

endpackage

/* rtl/core/mtss_unit.sv */
// Shared bit-serial arithmetic unit: shift-add multiply and restoring divide,
// one bit per cycle. Depends on mtss_pkg.
module mtss_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  mtss_pkg::unit_ctrl_type      ctrl,
   input  logic [mtss_pkg::ACC_W-1:0]   x,     // multiplicand or dividend
   input  logic [mtss_pkg::ACC_W-1:0]   y,     // multiplier or divisor
   output logic                         done,
   output logic [mtss_pkg::ACC_W-1:0]   acc,   // product or remainder
   output logic [mtss_pkg::ACC_W-1:0]   quo    // quotient
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   mtss_pkg::op_type              op_ff, op_in;
   logic [mtss_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [mtss_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic [mtss_pkg::ACC_W-1:0]    ra_ff, ra_in;
   logic [mtss_pkg::ACC_W-1:0]    rb_ff, rb_in;
   logic [mtss_pkg::ACC_W-1:0]    sum, trial, diff;
   logic                          ge;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      ra_ff  <= ra_in;
      rb_ff  <= rb_in;
   end

   // an adder for the multiply, a comparator and a subtractor for the divide
   assign sum   = acc_ff + ra_ff;
   assign trial = {acc_ff[mtss_pkg::ACC_W-2:0], rb_ff[mtss_pkg::ACC_W-1]};
   assign ge    = (trial >= ra_ff);
   assign diff  = trial - ra_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      ra_in   = ra_ff;
      rb_in   = rb_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         op_in   = ctrl.op;
         cnt_in  = ctrl.nbits;
         acc_in  = '0;
         ra_in   = (ctrl.op == mtss_pkg::OP_MUL) ? x : y;
         rb_in   = (ctrl.op == mtss_pkg::OP_MUL) ? y : x;
      end else if (busy_ff) begin
         case (op_ff)
            mtss_pkg::OP_MUL: begin
               if (rb_ff[0]) begin
                  acc_in = sum;
               end
               ra_in = {ra_ff[mtss_pkg::ACC_W-2:0], 1'b0};
               rb_in = {1'b0, rb_ff[mtss_pkg::ACC_W-1:1]};
            end
            mtss_pkg::OP_DIV: begin
               acc_in = ge ? diff : trial;
               rb_in  = {rb_ff[mtss_pkg::ACC_W-2:0], ge};
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == mtss_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign acc  = acc_ff;
   assign quo  = rb_ff;

endmodule

/* rtl/core/motion_to_scroll_scaler.sv */
// Top level of the motion to scroll scaler: stream ports, register file,
// sequencer and carry store. Depends on mtss_pkg and mtss_unit.

// Converts relative pointer events into scroll deltas, one transaction at a
// time. Events that are not scaled (not relative, other axes, X/Y without drag)
// go straight from the idle step to the output step.
// A scaled event runs through one bit-serial multiply/divide unit: 19 + 21
// multiply steps and a 58-step divide. The next request is taken only once the
// sequencer has passed its result to the output register and returned to idle.
// When the acceleration curve engages, two 16-step multiplies and a second
// 58-step divide follow. req_tready is high only while the sequencer is
// idle; a finished result waits in the output register while the next event
// is taken, and the sequencer stalls at its output step while that register
// is full and not being taken.
module motion_to_scroll_scaler (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mtss_pkg::REQ_DATA_W-1:0]   req_tdata,  // axis_code, delta, speed,
                                                         // drag_active, zero pad
   input  logic                              req_tuser,  // is_relative
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mtss_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // out_code, out_delta, zero pad
   // register write port
   input  logic                              csr_we,
   input  logic [mtss_pkg::REG_IDX_W-1:0]    csr_addr,
   input  logic [mtss_pkg::REG_W-1:0]        csr_wdata
);

   localparam int W = mtss_pkg::ACC_W;

   // registers
   logic [2:0]  axis_ff;
   logic [15:0] min_step_ff, max_delta_ff, dz_ff, gnum_ff, gden_ff, unum_ff, uden_ff;

   // sequencer and item state
   mtss_pkg::state_type st_ff, st_in;
   logic [2:0]   code_ff, code_in;
   logic [2:0]   ocode_ff, ocode_in;
   logic         neg_ff, neg_in;
   logic         vsign_ff, vsign_in;
   logic [20:0]  speed_ff, speed_in;
   logic [W-1:0] p_ff, p_in;
   logic [W-1:0] lm_ff, lm_in;
   logic [31:0]  rmag_ff, rmag_in;
   logic [W-1:0] cm_ff, cm_in;
   logic [15:0]  res_ff, res_in;
   logic [15:0]  rem_ff [4];
   logic         rem_we;
   logic [15:0]  rem_wdata;

   // response register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [2:0]   rsp_code_ff, rsp_code_in;
   logic [15:0]  rsp_delta_ff, rsp_delta_in;

   // unit interface
   mtss_pkg::unit_ctrl_type u_ctrl;
   logic [W-1:0] u_x, u_y, u_acc, u_quo;
   logic         u_done;

   // request field decode
   logic [2:0]  in_code;
   logic [15:0] in_delta;
   logic [20:0] in_speed;
   logic        in_drag, in_rel, in_wheel, in_xy_drag, in_scaled, req_acc;
   logic [15:0] in_dmag;
   logic [18:0] in_m;
   logic [1:0]  mode;
   logic        inv;

   // finishing logic
   logic [15:0] uden_eff, gden_eff, over, sat_p, sat_r, final_v;
   logic [W-1:0] p_abs;
   logic        csign, s2, curve_on;
   logic [16:0] mag1;

   assign in_code  = req_tdata[2:0];
   assign in_delta = req_tdata[18:3];
   assign in_speed = req_tdata[39:19];
   assign in_drag  = req_tdata[40];
   assign in_rel   = req_tuser;
   assign mode     = axis_ff[1:0];
   assign inv      = axis_ff[2];

   assign in_wheel   = (in_code == mtss_pkg::AXIS_VWHEEL) || (in_code == mtss_pkg::AXIS_HWHEEL);
   assign in_xy_drag = ((in_code == mtss_pkg::AXIS_X) || (in_code == mtss_pkg::AXIS_Y)) && in_drag;
   assign in_scaled  = in_rel && (in_wheel || in_xy_drag);
   assign in_dmag    = in_delta[15] ? (16'd0 - in_delta) : in_delta;
   assign in_m       = in_wheel ? {unum_ff, 3'b000} : {3'b000, unum_ff};

   assign req_tready = (st_ff == mtss_pkg::ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   assign uden_eff = (uden_ff == 16'd0) ? 16'd1 : uden_ff;
   assign gden_eff = (gden_ff == 16'd0) ? 16'd1 : gden_ff;
   assign p_abs    = p_ff[W-1] ? (W'(0) - p_ff) : p_ff;
   assign over     = lm_ff[15:0] - dz_ff;
   assign curve_on = (gnum_ff != 16'd0) && (lm_ff != '0) && (lm_ff > W'(dz_ff))
                     && (lm_ff[W-1:16] == '0);
   assign csign    = p_ff[W-1];

   // p saturated to 16 bits
   assign sat_p = p_ff[W-1] ? ((&p_ff[W-1:15]) ? p_ff[15:0] : 16'h8000)
                            : ((|p_ff[W-1:15]) ? 16'h7fff : p_ff[15:0]);
   // signed remainder (sign of p) saturated to 16 bits
   assign sat_r = csign ? ((rmag_ff >= 32'd32768) ? 16'h8000 : (16'd0 - rmag_ff[15:0]))
                        : ((rmag_ff >= 32'd32767) ? 16'h7fff : rmag_ff[15:0]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff      <= 3'd0;
         min_step_ff  <= 16'd0;
         max_delta_ff <= 16'd0;
         dz_ff        <= 16'd0;
         gnum_ff      <= 16'd0;
         gden_ff      <= 16'd1;
         unum_ff      <= 16'd1;
         uden_ff      <= 16'd1;
      end else if (csr_we) begin
         case (csr_addr)
            mtss_pkg::REG_AXIS_INV:  axis_ff      <= csr_wdata[2:0];
            mtss_pkg::REG_MIN_STEP:  min_step_ff  <= csr_wdata;
            mtss_pkg::REG_MAX_DELTA: max_delta_ff <= csr_wdata;
            mtss_pkg::REG_DEADZONE:  dz_ff        <= csr_wdata;
            mtss_pkg::REG_GAIN_NUM:  gnum_ff      <= csr_wdata;
            mtss_pkg::REG_GAIN_DEN:  gden_ff      <= csr_wdata;
            mtss_pkg::REG_UNIT_NUM:  unum_ff      <= csr_wdata;
            mtss_pkg::REG_UNIT_DEN:  uden_ff      <= csr_wdata;
            default:                 axis_ff      <= axis_ff;
         endcase
      end
   end

   // carry remainder per incoming axis
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            rem_ff[i] <= 16'd0;
         end
      end else if (rem_we) begin
         rem_ff[code_ff[1:0]] <= rem_wdata;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= mtss_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      code_ff      <= code_in;
      ocode_ff     <= ocode_in;
      neg_ff       <= neg_in;
      vsign_ff     <= vsign_in;
      speed_ff     <= speed_in;
      p_ff         <= p_in;
      lm_ff        <= lm_in;
      rmag_ff      <= rmag_in;
      cm_ff        <= cm_in;
      res_ff       <= res_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_delta_ff <= rsp_delta_in;
   end

   // final value: curve result, step / clamp rules, sign and saturation
   always_comb begin
      rem_wdata = sat_r;
      if ((min_step_ff != 16'd0) && (cm_ff < W'(min_step_ff))) begin
         mag1      = 17'd0;
         rem_wdata = sat_p;
      end else if ((max_delta_ff != 16'd0) && (cm_ff > W'(max_delta_ff))) begin
         mag1      = {1'b0, max_delta_ff};
         rem_wdata = 16'd0;
      end else if (csign) begin
         mag1 = (cm_ff >= W'(32768)) ? 17'd32768 : cm_ff[16:0];
      end else begin
         mag1 = (cm_ff >= W'(32767)) ? 17'd32767 : cm_ff[16:0];
      end
      s2 = csign ^ neg_ff;
      if (s2) begin
         final_v = (mag1 >= 17'd32768) ? 16'h8000 : (16'd0 - mag1[15:0]);
      end else begin
         final_v = (mag1 >= 17'd32767) ? 16'h7fff : mag1[15:0];
      end
   end

   // sequencer
   always_comb begin
      st_in        = st_ff;
      code_in      = code_ff;
      ocode_in     = ocode_ff;
      neg_in       = neg_ff;
      vsign_in     = vsign_ff;
      speed_in     = speed_ff;
      p_in         = p_ff;
      lm_in        = lm_ff;
      rmag_in      = rmag_ff;
      cm_in        = cm_ff;
      res_in       = res_ff;
      rem_we       = 1'b0;
      u_ctrl       = '{start: 1'b0, op: mtss_pkg::OP_MUL, nbits: '0};
      u_x          = '0;
      u_y          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_code_in  = rsp_code_ff;
      rsp_delta_in = rsp_delta_ff;
      case (st_ff)
         mtss_pkg::ST_IDLE: begin
            if (req_acc) begin
               code_in  = in_code;
               vsign_in = in_delta[15];
               speed_in = in_speed;
               neg_in   = (in_code == mtss_pkg::AXIS_Y) ^ inv;
               ocode_in = in_code;
               res_in   = in_delta;
               if (in_rel && (in_code == mtss_pkg::AXIS_VWHEEL) &&
                   ((mode == mtss_pkg::MODE_HORIZ) || ((mode == mtss_pkg::MODE_DRAG) && in_drag))) begin
                  ocode_in = mtss_pkg::AXIS_HWHEEL;
               end else if (in_rel && in_xy_drag) begin
                  ocode_in = (in_code == mtss_pkg::AXIS_X) ? mtss_pkg::AXIS_HWHEEL
                                                           : mtss_pkg::AXIS_VWHEEL;
               end
               if (in_scaled) begin
                  u_ctrl = '{start: 1'b1, op: mtss_pkg::OP_MUL,
                             nbits: mtss_pkg::CNT_W'(mtss_pkg::MUL1_STEPS)};
                  u_x    = W'(in_dmag);
                  u_y    = W'(in_m);
                  st_in  = mtss_pkg::ST_MUL1;
               end else begin
                  st_in = mtss_pkg::ST_OUT;
               end
            end
         end
         mtss_pkg::ST_MUL1: begin
            if (u_done) begin
               u_ctrl = '{start: 1'b1, op: mtss_pkg::OP_MUL,
                          nbits: mtss_pkg::CNT_W'(mtss_pkg::MUL2_STEPS)};
               u_x    = u_acc;
               u_y    = W'(speed_ff);
               st_in  = mtss_pkg::ST_MUL2;
            end
         end
         mtss_pkg::ST_MUL2: begin
            if (u_done) begin
               p_in  = (vsign_ff ? (W'(0) - u_acc) : u_acc)
                       + {{(W-16){rem_ff[code_ff[1:0]][15]}}, rem_ff[code_ff[1:0]]};
               st_in = mtss_pkg::ST_ADDREM;
            end
         end
         mtss_pkg::ST_ADDREM: begin
            u_ctrl = '{start: 1'b1, op: mtss_pkg::OP_DIV,
                       nbits: mtss_pkg::CNT_W'(mtss_pkg::DIV_STEPS)};
            u_x    = p_abs;
            u_y    = W'({uden_eff, 16'd0});
            st_in  = mtss_pkg::ST_DIV;
         end
         mtss_pkg::ST_DIV: begin
            if (u_done) begin
               lm_in   = u_quo;
               rmag_in = u_acc[31:0];
               st_in   = mtss_pkg::ST_CHK;
            end
         end
         mtss_pkg::ST_CHK: begin
            if (curve_on) begin
               u_ctrl = '{start: 1'b1, op: mtss_pkg::OP_MUL,
                          nbits: mtss_pkg::CNT_W'(mtss_pkg::SQ_STEPS)};
               u_x    = W'(over);
               u_y    = W'(over);
               st_in  = mtss_pkg::ST_SQ;
            end else begin
               cm_in = lm_ff;
               st_in = mtss_pkg::ST_FIN;
            end
         end
         mtss_pkg::ST_SQ: begin
            if (u_done) begin
               u_ctrl = '{start: 1'b1, op: mtss_pkg::OP_MUL,
                          nbits: mtss_pkg::CNT_W'(mtss_pkg::GAIN_STEPS)};
               u_x    = u_acc;
               u_y    = W'(gnum_ff);
               st_in  = mtss_pkg::ST_GAIN;
            end
         end
         mtss_pkg::ST_GAIN: begin
            if (u_done) begin
               u_ctrl = '{start: 1'b1, op: mtss_pkg::OP_DIV,
                          nbits: mtss_pkg::CNT_W'(mtss_pkg::DIV_STEPS)};
               u_x    = u_acc;
               u_y    = W'(gden_eff);
               st_in  = mtss_pkg::ST_CDIV;
            end
         end
         mtss_pkg::ST_CDIV: begin
            if (u_done) begin
               cm_in = lm_ff + u_quo;
               st_in = mtss_pkg::ST_FIN;
            end
         end
         mtss_pkg::ST_FIN: begin
            rem_we = 1'b1;
            res_in = final_v;
            st_in  = mtss_pkg::ST_OUT;
         end
         mtss_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = ocode_ff;
               rsp_delta_in = res_ff;
               st_in        = mtss_pkg::ST_IDLE;
            end
         end
         default: begin
            st_in = mtss_pkg::ST_IDLE;
         end
      endcase
   end

   mtss_unit u_unit (
      .clock (clock),
      .reset (reset),
      .ctrl  (u_ctrl),
      .x     (u_x),
      .y     (u_y),
      .done  (u_done),
      .acc   (u_acc),
      .quo   (u_quo)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_delta_ff, rsp_code_ff};

endmodule

/* rtl/core/mtss_checker.sv */
// Port-level checker for the motion to scroll scaler, bound to the top level.
// Depends on assert_macros.svh and mtss_pkg.
`include "assert_macros.svh"

module mtss_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [mtss_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   // no response right after reset
   `MTSS_ASSERT_NR(a_rst_rsp_idle, clock, reset |=> !rsp_tvalid)

   // one event at a time: busy after taking a transaction
   `MTSS_ASSERT(a_busy_after_acc, clock, reset, (req_tvalid && req_tready) |=> !req_tready)

   // a stalled response holds
   `MTSS_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))

   // pad bits of the response stay zero
   `MTSS_ASSERT(a_rsp_pad, clock, reset, rsp_tvalid |-> (rsp_tdata[23:19] == 5'd0))

endmodule

bind motion_to_scroll_scaler mtss_checker u_mtss_checker (.*);

/* tb/motion_to_scroll_scaler_test.sv */
// Self-checking testbench for the motion to scroll scaler: drives pointer
// events over the request stream and checks scroll deltas on the response.
// Depends on mtss_pkg and the motion_to_scroll_scaler RTL.

class scroll_scoreboard;
   // configuration and carry copies
   bit [2:0]  axis_inv;
   bit [15:0] min_step, max_delta, deadzone, gain_num, gain_den, unit_num, unit_den;
   shortint   carry [4];
   bit [18:0] expected_q [$];
   int        errors;

   function new();
      reset_state();
      errors = 0;
   endfunction

   function void reset_state();
      axis_inv = 0; min_step = 0; max_delta = 0; deadzone = 0; gain_num = 0;
      gain_den = 1; unit_num = 1; unit_den = 1;
      foreach (carry[i]) carry[i] = 0;
   endfunction

   function void write_reg(mtss_pkg::reg_idx_type idx, bit [15:0] v);
      case (idx)
         mtss_pkg::REG_AXIS_INV:  axis_inv  = v[2:0];
         mtss_pkg::REG_MIN_STEP:  min_step  = v;
         mtss_pkg::REG_MAX_DELTA: max_delta = v;
         mtss_pkg::REG_DEADZONE:  deadzone  = v;
         mtss_pkg::REG_GAIN_NUM:  gain_num  = v;
         mtss_pkg::REG_GAIN_DEN:  gain_den  = v;
         mtss_pkg::REG_UNIT_NUM:  unit_num  = v;
         default:                 unit_den  = v;
      endcase
   endfunction

   function longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function longint absl(longint v);
      return v < 0 ? -v : v;
   endfunction

   // linear scale, curve, min step, clamp; updates carry
   function longint scale_delta(longint val, longint mul, longint speed, int idx);
      longint den, p, lin, c, m, over, gd;
      den = longint'(unit_den == 0 ? 1 : unit_den) * 65536;
      p = val * mul * speed + longint'(carry[idx]);
      lin = p / den;
      m = absl(lin);
      c = lin;
      if (lin != 0 && gain_num != 0 && m > deadzone && m < 65536) begin
         gd = gain_den == 0 ? 1 : gain_den;
         over = m - deadzone;
         c = m + (over * over * longint'(gain_num)) / gd;
         if (lin < 0) c = -c;
      end
      if (min_step != 0 && absl(c) < min_step) begin
         carry[idx] = shortint'(sat16(p));
         return 0;
      end
      if (max_delta != 0 && absl(c) > max_delta) begin
         carry[idx] = 0;
         return c < 0 ? -longint'(max_delta) : longint'(max_delta);
      end
      carry[idx] = shortint'(sat16(p - lin * den));
      return sat16(c);
   endfunction

   // note an accepted event and queue its scroll output
   function void note_event(bit rel, bit [2:0] code, bit [15:0] delta, bit [20:0] speed,
                            bit drag);
      bit [2:0] ocode;
      longint   r;
      mtss_pkg::wheel_mode_type mode;
      mode = mtss_pkg::wheel_mode_type'(axis_inv[1:0]);
      ocode = code;
      r = longint'($signed(delta));
      if (rel) begin
         if (code == mtss_pkg::AXIS_VWHEEL || code == mtss_pkg::AXIS_HWHEEL) begin
            if (code == mtss_pkg::AXIS_VWHEEL &&
                (mode == mtss_pkg::MODE_HORIZ || (mode == mtss_pkg::MODE_DRAG && drag)))
               ocode = mtss_pkg::AXIS_HWHEEL;
            r = scale_delta(r, longint'(unit_num) * 8, speed, code);
            if (axis_inv[2]) r = -r;
         end else if ((code == mtss_pkg::AXIS_X || code == mtss_pkg::AXIS_Y) && drag) begin
            ocode = code == mtss_pkg::AXIS_X ? mtss_pkg::AXIS_HWHEEL : mtss_pkg::AXIS_VWHEEL;
            r = scale_delta(r, unit_num, speed, code);
            if (code == mtss_pkg::AXIS_Y) r = -r;
            if (axis_inv[2]) r = -r;
         end
      end
      r = sat16(r);
      expected_q.push_back({r[15:0], ocode});
   endfunction

   function void check_result(bit [23:0] data);
      bit [18:0] exp_v;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result code=%0d delta=%0d", $time, data[2:0],
                  $signed(data[18:3]));
         errors++;
         return;
      end
      exp_v = expected_q.pop_front();
      if (data[2:0] != exp_v[2:0]) begin
         $display("%0t: out_code expected %0d actual %0d", $time, exp_v[2:0], data[2:0]);
         errors++;
      end
      if (data[18:3] != exp_v[18:3]) begin
         $display("%0t: out_delta expected %0d actual %0d", $time, $signed(exp_v[18:3]),
                  $signed(data[18:3]));
         errors++;
      end
   endfunction
endclass

module motion_to_scroll_scaler_test;

   localparam int WATCHDOG = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        csr_we = 0;
   logic [2:0]  csr_addr = '0;
   logic [15:0] csr_wdata = '0;

   scroll_scoreboard sb = new();
   bit hold_off = 0;
   bit timed_out = 0;
   int idle_cycles = 0;

   motion_to_scroll_scaler dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // mostly short gaps, a few long ones
   function int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 40) return 0;
      if (k < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   // response side: random stalls, plus a long hold-off on request
   initial begin
      int g;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (3000) @(posedge clock);
            hold_off = 0;
         end
         g = gap_len();
         if (g > 0) begin
            rsp_tready <= 0;
            repeat (g - 1) @(posedge clock);
            @(posedge clock);
         end
         rsp_tready <= 1;
      end
   end

   // result checking and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles > WATCHDOG) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // valid stays up after a transaction until the next gap starts
   task automatic send_event(bit rel, bit [2:0] code, bit [15:0] delta, bit [20:0] speed,
                             bit drag, bit no_gap = 0);
      int g;
      g = no_gap ? 0 : gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= rel;
      req_tdata  <= {6'd0, drag, speed, delta, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_event(rel, code, delta, speed, drag);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   task automatic write_reg(mtss_pkg::reg_idx_type idx, bit [15:0] v);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      sb.write_reg(idx, v);
      @(posedge clock);
   endtask

   // random event, biased to scaled traffic
   task automatic random_event(bit no_gap = 0);
      bit [2:0]  code;
      bit [20:0] speed;
      bit [15:0] delta;
      int k;
      code = 3'($urandom_range(0, 9) < 8 ? $urandom_range(0, 3) : $urandom_range(4, 7));
      k = $urandom_range(0, 9);
      speed = 21'(k < 7 ? $urandom_range(0, 1048576) : (k < 8 ? 1048576 : $urandom));
      delta = 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 80) - 40);
      send_event($urandom_range(0, 9) != 0, code, delta, speed, $urandom_range(0, 3) != 0,
                 no_gap);
   endtask

   task automatic random_config();
      write_reg(mtss_pkg::REG_AXIS_INV, 16'($urandom_range(0, 7)));
      write_reg(mtss_pkg::REG_MIN_STEP,
                16'($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 20)));
      write_reg(mtss_pkg::REG_MAX_DELTA,
                16'($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3000)));
      write_reg(mtss_pkg::REG_DEADZONE,
                16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 30)));
      write_reg(mtss_pkg::REG_GAIN_NUM, 16'($urandom_range(0, 2) == 0 ? 0 : $urandom));
      write_reg(mtss_pkg::REG_GAIN_DEN, 16'($urandom_range(0, 5) == 0 ? 0 : $urandom));
      write_reg(mtss_pkg::REG_UNIT_NUM,
                16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8)));
      write_reg(mtss_pkg::REG_UNIT_DEN,
                16'($urandom_range(0, 5) == 0 ? 0 : $urandom_range(0, 8)));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset settings, passthrough cases, extremes
      send_event(0, mtss_pkg::AXIS_Y, 16'h8000, 21'd65536, 1);
      send_event(1, 3'd4, 16'h7fff, 21'd65536, 1);
      send_event(1, 3'd7, 16'h8000, 21'd0, 0);
      send_event(1, mtss_pkg::AXIS_X, 16'd5, 21'd65536, 0);
      send_event(1, mtss_pkg::AXIS_X, 16'h7fff, 21'd1048576, 1);
      send_event(1, mtss_pkg::AXIS_Y, 16'h8000, 21'd1048576, 1);
      send_event(1, mtss_pkg::AXIS_Y, 16'h8000, 21'd65536, 1);
      send_event(1, mtss_pkg::AXIS_VWHEEL, 16'h0001, 21'd32768, 0);
      send_event(1, mtss_pkg::AXIS_HWHEEL, 16'hffff, 21'h1fffff, 1);
      drain();
      // horizontal mode, invert, min step, clamp, curve, zero divisors
      write_reg(mtss_pkg::REG_AXIS_INV, 16'd5);
      write_reg(mtss_pkg::REG_MIN_STEP, 16'd3);
      write_reg(mtss_pkg::REG_MAX_DELTA, 16'd100);
      write_reg(mtss_pkg::REG_DEADZONE, 16'd2);
      write_reg(mtss_pkg::REG_GAIN_NUM, 16'd3);
      write_reg(mtss_pkg::REG_GAIN_DEN, 16'd0);
      write_reg(mtss_pkg::REG_UNIT_NUM, 16'd1);
      write_reg(mtss_pkg::REG_UNIT_DEN, 16'd0);
      send_event(1, mtss_pkg::AXIS_VWHEEL, 16'd1, 21'd16384, 0);
      send_event(1, mtss_pkg::AXIS_VWHEEL, 16'd1, 21'd65536, 0);
      send_event(1, mtss_pkg::AXIS_X, 16'd4, 21'd65536, 1);
      send_event(1, mtss_pkg::AXIS_Y, 16'hfffc, 21'd65536, 1);
      send_event(1, mtss_pkg::AXIS_HWHEEL, 16'd200, 21'd65536, 1);
      drain();
      write_reg(mtss_pkg::REG_AXIS_INV, 16'd2);
      write_reg(mtss_pkg::REG_MIN_STEP, 16'hffff);
      write_reg(mtss_pkg::REG_MAX_DELTA, 16'hffff);
      write_reg(mtss_pkg::REG_DEADZONE, 16'hffff);
      write_reg(mtss_pkg::REG_GAIN_NUM, 16'hffff);
      write_reg(mtss_pkg::REG_GAIN_DEN, 16'hffff);
      write_reg(mtss_pkg::REG_UNIT_NUM, 16'hffff);
      write_reg(mtss_pkg::REG_UNIT_DEN, 16'hffff);
      send_event(1, mtss_pkg::AXIS_VWHEEL, 16'h7fff, 21'd1048576, 1);
      send_event(1, mtss_pkg::AXIS_VWHEEL, 16'h8000, 21'd1048576, 0);
      drain();
      write_reg(mtss_pkg::REG_AXIS_INV, 16'd3);
      send_event(1, mtss_pkg::AXIS_VWHEEL, 16'h1234, 21'd70000, 1);
      drain();

      // random phases with fresh settings
      for (int ph = 0; ph < 30; ph++) begin
         random_config();
         if (ph == 3) begin
            hold_off = 1;
            for (int i = 0; i < 10; i++) random_event(1);
         end
         for (int i = 0; i < 30; i++) random_event();
         drain();
      end

      if (sb.expected_q.size() == 0 && sb.errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
